// File: rtl/ffra_pkg.sv
// ffra_pkg: shared types and codes of the first-fit region allocator
// no dependencies; used by ffra_cell and first_fit_region_allocator_top through scoped names
`timescale 1ns / 1ps

package ffra_pkg;

	// command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_COMPACT = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_NO_SPACE = 3'd1;
	localparam logic [2:0] STAT_NO_SLOT  = 3'd2;
	localparam logic [2:0] STAT_BAD_SLOT = 3'd3;
	localparam logic [2:0] STAT_NO_MOVE  = 3'd4;

	// register indexes
	localparam logic REG_POOL  = 1'b0;
	localparam logic REG_ALIGN = 1'b1;

	// reset values of the registers
	localparam logic [31:0] POOL_RESET  = 32'd65536;
	localparam logic [4:0]  ALIGN_RESET = 5'd8;

	// moves reported by one compact
	localparam int unsigned MAX_MOVES = 16;

	// slot index field inside cell traffic (up to 256 slots)
	localparam int unsigned SLOT_IDX_W = 8;

	// token handed along the cell chain: ordered search for the next region
	typedef struct packed {
		logic                  have_prev;
		logic [31:0]           prev_start;
		logic [SLOT_IDX_W-1:0] prev_slot;
		logic                  found;
		logic [31:0]           best_start;
		logic [SLOT_IDX_W-1:0] best_slot;
		logic [31:0]           best_len;
	} tok_t;

	// broadcast update of one cell
	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] slot;
		logic                  wr_start;
		logic [31:0]           start;
		logic                  wr_len;
		logic [31:0]           len;
		logic                  set_live;
		logic                  clr_live;
	} cell_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOK,
		ST_EVAL,
		ST_END1,
		ST_END2,
		ST_ADONE,
		ST_FREE,
		ST_CDONE
	} state_t;

endpackage

// File: rtl/ffra_if.sv
// ffra_req_if / ffra_rsp_if: valid-ready channels for commands and results
// no dependencies
`timescale 1ns / 1ps

interface ffra_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] alloc_bytes;
	logic [3:0]  slot_in;

	modport source (output valid, cmd, alloc_bytes, slot_in, input ready);
	modport sink (input valid, cmd, alloc_bytes, slot_in, output ready);
endinterface

interface ffra_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic [31:0] region_offset;
	logic [31:0] old_offset;
	logic [31:0] move_length;
	logic        last;

	modport source (output valid, status, slot_out, region_offset, old_offset, move_length,
		last, input ready);
	modport sink (input valid, status, slot_out, region_offset, old_offset, move_length,
		last, output ready);
endinterface

// File: rtl/ffra_ram.sv
// ffra_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module ffra_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/ffra_cell.sv
// ffra_cell: one region slot (start, length, live) and one stage of the search chain
// depends on ffra_pkg
`timescale 1ns / 1ps

module ffra_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ffra_pkg::cell_wr_t wr,
	input  ffra_pkg::tok_t     tok_in,
	output ffra_pkg::tok_t     tok_out,
	output logic               live
);

	localparam logic [ffra_pkg::SLOT_IDX_W-1:0] MY_IDX = ffra_pkg::SLOT_IDX_W'(IDX);

	logic [31:0]    start_q;
	logic [31:0]    len_q;
	logic           live_q;
	logic           hit;
	logic           after_prev;
	logic           below_best;
	logic           take;
	ffra_pkg::tok_t tok_d;

	assign hit  = wr.en && (wr.slot == MY_IDX);
	assign live = live_q;

	// live flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (hit) begin
			if (wr.set_live) begin
				live_q <= 1'b1;
			end else if (wr.clr_live) begin
				live_q <= 1'b0;
			end
		end
	end

	// region fields
	always_ff @(posedge clk) begin
		if (hit && wr.wr_start) begin
			start_q <= wr.start;
		end
		if (hit && wr.wr_len) begin
			len_q <= wr.len;
		end
	end

	// compare this cell's (start, slot) key with the token
	assign after_prev = !tok_in.have_prev ||
		({start_q, MY_IDX} > {tok_in.prev_start, tok_in.prev_slot});
	assign below_best = !tok_in.found ||
		({start_q, MY_IDX} < {tok_in.best_start, tok_in.best_slot});
	assign take = live_q && after_prev && below_best;

	// token as it leaves this cell
	always_comb begin
		tok_d = tok_in;
		if (take) begin
			tok_d.found      = 1'b1;
			tok_d.best_start = start_q;
			tok_d.best_slot  = MY_IDX;
			tok_d.best_len   = len_q;
		end
	end

	// hand the token on to the neighbour
	always_ff @(posedge clk) begin
		tok_out <= tok_d;
	end

endmodule

// File: rtl/first_fit_region_allocator_top.sv
// first_fit_region_allocator_top: sequencer, registers, free-slot stack and cell chain
// depends on ffra_pkg, ffra_if, ffra_ram, ffra_cell
`timescale 1ns / 1ps

// Use: commands arrive on the req channel (allocate, free, compact) and results leave
// on the rsp channel, one word per result, the final word of a command marked by last.
// Allocate and free give one word; compact gives one word per region that moves (at most
// 16), or a single nothing-moved word. Command 3 is taken and gives nothing.
// pool_bytes and align_log2 sit on the APB port at byte addresses 0 and 4; write them
// only while no command is in flight.
// One command is worked at a time. Each search for the next region in address order is
// a token that walks the chain of SLOT_COUNT cells, one cell a cycle; after the pass the
// result is evaluated, and the end of the region found is rounded up to the alignment
// and, if it lies beyond the cursor, becomes the new cursor. Allocate repeats the search
// for each region it passes, compact for each live region; free needs no search. The
// sequencer goes back to idle before it takes the next command.
// A result sits in an output register; a stalled receiver holds the sequencer at its
// next result while the command already accepted keeps working up to that point.
// Reset clears all slots to unused, the free-slot stack to empty and the registers to
// pool 65536, alignment 2^8; no clearing pass is needed.
module first_fit_region_allocator_top #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ffra_req_if.sink    req,
	ffra_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int IW = ffra_pkg::SLOT_IDX_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOT_COUNT);
	localparam logic [SW-1:0] LAST_CELL = SW'(SLOT_COUNT - 1);

	// configuration registers
	logic [31:0] pool_q;
	logic [4:0]  align_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= ffra_pkg::POOL_RESET;
			align_q <= ffra_pkg::ALIGN_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == ffra_pkg::REG_POOL) begin
				pool_q <= pwdata;
			end else begin
				align_q <= pwdata[4:0];
			end
		end
	end

	// register read back
	always_comb begin
		if (paddr[2] == ffra_pkg::REG_POOL) begin
			prdata = pool_q;
		end else begin
			prdata = {27'd0, align_q};
		end
	end

	// sequencer state
	ffra_pkg::state_t state_q, state_d;
	logic [1:0]    op_q;
	logic [31:0]   bytes_q;
	logic [3:0]    slot_in_q;
	logic [33:0]   cur_q;
	logic [32:0]   e_q;
	logic [33:0]   r_q;
	logic          have_prev_q;
	logic [31:0]   prev_start_q;
	logic [IW-1:0] prev_slot_q;
	logic [SW-1:0] cnt_q;
	logic [4:0]    k_q;
	logic          fail_q;
	logic [CW-1:0] depth_q;
	logic [CW-1:0] handed_q;

	// pending move of a compact, sent once the next one (or the end) is known
	logic          pend_v_q;
	logic [3:0]    pend_slot_q;
	logic [31:0]   pend_new_q;
	logic [31:0]   pend_old_q;
	logic [31:0]   pend_len_q;

	// output register
	logic          out_v_q;
	logic [2:0]    out_status_q;
	logic [3:0]    out_slot_q;
	logic [31:0]   out_off_q;
	logic [31:0]   out_old_q;
	logic [31:0]   out_len_q;
	logic          out_last_q;
	logic          out_free;
	logic          out_load;

	assign out_free = !out_v_q || rsp.ready;

	// cell chain
	ffra_pkg::tok_t     tok_chain [SLOT_COUNT+1];
	ffra_pkg::cell_wr_t cell_wr;
	logic [(2**SW)-1:0] live_vec;
	ffra_pkg::tok_t     tok;

	assign tok = tok_chain[SLOT_COUNT];

	assign tok_chain[0] = '{have_prev: have_prev_q, prev_start: prev_start_q,
		prev_slot: prev_slot_q, default: '0};

	generate
		if ((2**SW) > SLOT_COUNT) begin : g_pad
			assign live_vec[(2**SW)-1:SLOT_COUNT] = '0;
		end
		for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
			ffra_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr      (cell_wr),
				.tok_in  (tok_chain[i]),
				.tok_out (tok_chain[i+1]),
				.live    (live_vec[i])
			);
		end
	endgenerate

	// free-slot stack
	logic          stk_we;
	logic [SW-1:0] stk_waddr;
	logic [SW-1:0] stk_raddr;
	logic [3:0]    stk_rdata;
	logic [CW-1:0] depth_m1;

	assign depth_m1  = depth_q - CW'(1);
	assign stk_raddr = depth_m1[SW-1:0];
	assign stk_waddr = depth_q[SW-1:0];

	ffra_ram #(.WIDTH(4), .DEPTH(SLOT_COUNT)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (slot_in_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// search evaluation
	logic [31:0]   lim;
	logic          fit;
	logic          mv;
	logic          mv_stall;
	logic [31:0]   base;
	logic [33:0]   amask;
	logic          in_range;
	logic [IW-1:0] sin_ext;
	logic          free_ok;
	logic [SW-1:0] new_slot;
	logic          take_stack;
	logic          take_fresh;

	assign amask = (34'd1 << align_q) - 34'd1;

	always_comb begin
		if (tok.found && (tok.best_start < pool_q)) begin
			lim = tok.best_start;
		end else begin
			lim = pool_q;
		end
	end

	assign fit      = (35'(cur_q) + 35'(bytes_q)) <= 35'(lim);
	assign mv       = tok.found && ({2'b00, tok.best_start} > cur_q) &&
		(k_q < 5'(ffra_pkg::MAX_MOVES));
	assign mv_stall = mv && pend_v_q && !out_free;
	// a moved region ends from its new start, any other from its own start
	assign base     = (op_q == ffra_pkg::CMD_COMPACT && mv) ? cur_q[31:0] : tok.best_start;

	assign sin_ext  = IW'(slot_in_q);
	assign in_range = {1'b0, sin_ext} < (IW + 1)'(SLOT_COUNT);
	assign free_ok  = in_range && live_vec[sin_ext[SW-1:0]];

	assign take_stack = (depth_q != '0);
	assign take_fresh = !take_stack && (handed_q < SLOTS_C);
	assign new_slot   = take_stack ? SW'(stk_rdata) : handed_q[SW-1:0];

	// a word enters the output register
	assign out_load =
		(state_q == ffra_pkg::ST_EVAL && op_q == ffra_pkg::CMD_COMPACT && mv &&
			!mv_stall && pend_v_q) ||
		((state_q == ffra_pkg::ST_ADONE || state_q == ffra_pkg::ST_FREE ||
			state_q == ffra_pkg::ST_CDONE) && out_free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffra_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.cmd == ffra_pkg::CMD_ALLOC || req.cmd == ffra_pkg::CMD_COMPACT) begin
						state_d = ffra_pkg::ST_TOK;
					end else if (req.cmd == ffra_pkg::CMD_FREE) begin
						state_d = ffra_pkg::ST_FREE;
					end
				end
			end
			ffra_pkg::ST_TOK: begin
				if (cnt_q == LAST_CELL) begin
					state_d = ffra_pkg::ST_EVAL;
				end
			end
			ffra_pkg::ST_EVAL: begin
				if (op_q == ffra_pkg::CMD_ALLOC) begin
					if (fit || !tok.found) begin
						state_d = ffra_pkg::ST_ADONE;
					end else begin
						state_d = ffra_pkg::ST_END1;
					end
				end else if (!tok.found) begin
					state_d = ffra_pkg::ST_CDONE;
				end else if (!mv_stall) begin
					state_d = ffra_pkg::ST_END1;
				end
			end
			ffra_pkg::ST_END1: state_d = ffra_pkg::ST_END2;
			ffra_pkg::ST_END2: state_d = ffra_pkg::ST_TOK;
			ffra_pkg::ST_ADONE, ffra_pkg::ST_FREE, ffra_pkg::ST_CDONE: begin
				if (out_free) begin
					state_d = ffra_pkg::ST_IDLE;
				end
			end
			default: state_d = ffra_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, cell updates, stack push
	assign req.ready = (state_q == ffra_pkg::ST_IDLE);

	always_comb begin
		cell_wr = '0;
		stk_we  = 1'b0;
		case (state_q)
			ffra_pkg::ST_EVAL: begin
				if (op_q == ffra_pkg::CMD_COMPACT && mv && !mv_stall) begin
					cell_wr.en       = 1'b1;
					cell_wr.slot     = tok.best_slot;
					cell_wr.wr_start = 1'b1;
					cell_wr.start    = cur_q[31:0];
				end
			end
			ffra_pkg::ST_ADONE: begin
				if (out_free && !fail_q && (take_stack || take_fresh)) begin
					cell_wr.en       = 1'b1;
					cell_wr.slot     = IW'(new_slot);
					cell_wr.wr_start = 1'b1;
					cell_wr.start    = cur_q[31:0];
					cell_wr.wr_len   = 1'b1;
					cell_wr.len      = bytes_q;
					cell_wr.set_live = 1'b1;
				end
			end
			ffra_pkg::ST_FREE: begin
				if (out_free && free_ok) begin
					cell_wr.en       = 1'b1;
					cell_wr.slot     = sin_ext;
					cell_wr.clr_live = 1'b1;
					stk_we           = (depth_q < SLOTS_C);
				end
			end
			default: begin
				cell_wr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ffra_pkg::ST_IDLE;
			depth_q  <= '0;
			handed_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			cnt_q <= (state_q == ffra_pkg::ST_TOK) ? cnt_q + SW'(1) : '0;
			case (state_q)
				ffra_pkg::ST_IDLE: begin
					pend_v_q <= 1'b0;
				end
				ffra_pkg::ST_EVAL: begin
					if (op_q == ffra_pkg::CMD_COMPACT && mv && !mv_stall) begin
						pend_v_q <= 1'b1;
					end
				end
				ffra_pkg::ST_ADONE: begin
					if (out_free) begin
						if (!fail_q && take_stack) begin
							depth_q <= depth_m1;
						end else if (!fail_q && take_fresh) begin
							handed_q <= handed_q + CW'(1);
						end
					end
				end
				ffra_pkg::ST_FREE: begin
					if (out_free && free_ok && depth_q < SLOTS_C) begin
						depth_q <= depth_q + CW'(1);
					end
				end
				ffra_pkg::ST_CDONE: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					pend_v_q <= pend_v_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffra_pkg::ST_IDLE: begin
				op_q        <= req.cmd;
				bytes_q     <= req.alloc_bytes;
				slot_in_q   <= req.slot_in;
				cur_q       <= '0;
				have_prev_q <= 1'b0;
				k_q         <= '0;
			end
			ffra_pkg::ST_EVAL: begin
				fail_q <= !fit;
				if (!(op_q == ffra_pkg::CMD_COMPACT && mv_stall)) begin
					e_q          <= 33'(base) + 33'(tok.best_len);
					have_prev_q  <= 1'b1;
					prev_start_q <= tok.best_start;
					prev_slot_q  <= tok.best_slot;
				end
				if (op_q == ffra_pkg::CMD_COMPACT && mv && !mv_stall) begin
					k_q         <= k_q + 5'd1;
					pend_slot_q <= tok.best_slot[3:0];
					pend_new_q  <= cur_q[31:0];
					pend_old_q  <= tok.best_start;
					pend_len_q  <= tok.best_len;
					// the previous move goes out once this one is known
					if (pend_v_q) begin
						out_status_q <= ffra_pkg::STAT_OK;
						out_slot_q   <= pend_slot_q;
						out_off_q    <= pend_new_q;
						out_old_q    <= pend_old_q;
						out_len_q    <= pend_len_q;
						out_last_q   <= 1'b0;
					end
				end
			end
			ffra_pkg::ST_END1: begin
				r_q <= (34'(e_q) + amask) & ~amask;
			end
			ffra_pkg::ST_END2: begin
				if (r_q > cur_q) begin
					cur_q <= r_q;
				end
			end
			ffra_pkg::ST_ADONE: begin
				if (out_free) begin
					out_old_q  <= '0;
					out_len_q  <= '0;
					out_last_q <= 1'b1;
					if (fail_q) begin
						out_status_q <= ffra_pkg::STAT_NO_SPACE;
						out_slot_q   <= '0;
						out_off_q    <= '0;
					end else if (take_stack || take_fresh) begin
						out_status_q <= ffra_pkg::STAT_OK;
						out_slot_q   <= 4'(new_slot);
						out_off_q    <= cur_q[31:0];
					end else begin
						out_status_q <= ffra_pkg::STAT_NO_SLOT;
						out_slot_q   <= '0;
						out_off_q    <= '0;
					end
				end
			end
			ffra_pkg::ST_FREE: begin
				if (out_free) begin
					out_status_q <= free_ok ? ffra_pkg::STAT_OK : ffra_pkg::STAT_BAD_SLOT;
					out_slot_q   <= slot_in_q;
					out_off_q    <= '0;
					out_old_q    <= '0;
					out_len_q    <= '0;
					out_last_q   <= 1'b1;
				end
			end
			ffra_pkg::ST_CDONE: begin
				if (out_free) begin
					out_last_q <= 1'b1;
					if (pend_v_q) begin
						out_status_q <= ffra_pkg::STAT_OK;
						out_slot_q   <= pend_slot_q;
						out_off_q    <= pend_new_q;
						out_old_q    <= pend_old_q;
						out_len_q    <= pend_len_q;
					end else begin
						out_status_q <= ffra_pkg::STAT_NO_MOVE;
						out_slot_q   <= '0;
						out_off_q    <= '0;
						out_old_q    <= '0;
						out_len_q    <= '0;
					end
				end
			end
			default: begin
				fail_q <= fail_q;
			end
		endcase
	end

	// result channel
	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot_out      = out_slot_q;
	assign rsp.region_offset = out_off_q;
	assign rsp.old_offset    = out_old_q;
	assign rsp.move_length   = out_len_q;
	assign rsp.last          = out_last_q;

	// checks on the sequencer
	a_nomove_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ffra_pkg::STAT_NO_MOVE |-> rsp.last)
		else $error("nothing-moved word without last");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SLOTS_C && handed_q <= SLOTS_C)
		else $error("free-slot stack or handed count beyond slot count");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffra_pkg::ST_CDONE && out_free |=> !pend_v_q)
		else $error("pending move left after compact end");

	a_eval_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffra_pkg::ST_EVAL |-> $past(state_q) == ffra_pkg::ST_TOK ||
		$past(state_q) == ffra_pkg::ST_EVAL)
		else $error("search result used before the token finished its pass");

endmodule
